>>> sv/alr_pkg.sv
// shared types and constants for the antialiased line rasterizer
`default_nettype none

package alr_pkg;

    // fixed field widths
    localparam int COORD_W  = 15;
    localparam int PIX_W    = 12;
    localparam int COLOR_W  = 32;
    localparam int OFF_W    = 26;
    localparam int PITCH_W  = 15;
    localparam int BPP_W    = 3;
    localparam int ALPHA_LO = 24;
    localparam int ALPHA_W  = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SELECT = 2'd3;

    // configuration reset values
    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 32'hFFFF_FFFF;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST  = 15'd8192;
    localparam logic [BPP_W-1:0]   BPP_RST        = 3'd4;

    // item kinds
    localparam logic KIND_SETUP = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_AXES,
        ST_SET_ORDER,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PIX_SETUP,
        ST_PIX_MUL,
        ST_PIX_EMIT
    } alr_state_t;

endpackage

`default_nettype wire

>>> sv/antialiased_line_rasterizer.sv
// top level of the wu-style antialiased line rasterizer
//
// usage: configuration is written through cfg_we / cfg_index / cfg_data while
// the block is idle. input items arrive on in_valid / in_ready. a setup item
// (kind 0) loads a line and produces no pixel; after it is taken in_ready stays
// low through the axis choice, the endpoint ordering and the bit-serial
// gradient divider (one quotient bit a cycle); the divider is skipped when
// the major axis has zero length. a step item (kind 1) produces one or two
// pixels on out_valid / out_ready. each pixel goes through a setup state, a
// bit-serial multiply (row*pitch + col*bpp and alpha*weight share the same
// bit loop, one row bit per cycle) and a load of the output register. in_ready
// stays low until the last pixel of the item is loaded. a step with no line
// loaded is taken and produces nothing. the output register holds a pixel
// while the receiver stalls; the block keeps working toward the next pixel
// and waits only when that one is ready to load. after the last pixel of an
// item is loaded, the next input item is accepted even if the receiver
// still stalls.
// reset: configuration returns to its defaults, no line is loaded and the
// output register is empty.
`default_nettype none

module antialiased_line_rasterizer
    import alr_pkg::*;
#(
    parameter int COORD_INT_BITS = 11,
    parameter int GRAD_FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_data,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  kind,
    input  wire logic [COORD_W-1:0]    start_x,
    input  wire logic [COORD_W-1:0]    start_y,
    input  wire logic [COORD_W-1:0]    end_x,
    input  wire logic [COORD_W-1:0]    end_y,
    // output items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_W-1:0]           pixel_col,
    output logic [PIX_W-1:0]           pixel_row,
    output logic [COLOR_W-1:0]         pixel_color,
    output logic [OFF_W-1:0]           byte_offset,
    output logic                       buffer,
    output logic                       line_done,
    output logic                       last
);

    localparam int CFB      = COORD_W - COORD_INT_BITS;
    localparam int MB       = COORD_INT_BITS + GRAD_FRAC_BITS + 1;
    localparam int SW       = GRAD_FRAC_BITS + 2;
    localparam int WW       = GRAD_FRAC_BITS + 1;
    localparam int AW       = GRAD_FRAC_BITS + ALPHA_W;
    localparam int MINOR_SH = GRAD_FRAC_BITS - CFB;
    localparam int WIDE_W   = 16;
    localparam int MUL_W    = 4;
    localparam logic [WIDE_W-1:0] COORD_ONE = WIDE_W'(1) << CFB;
    localparam logic [WW-1:0]     WEIGHT_ONE = WW'(1) << GRAD_FRAC_BITS;

    // configuration registers
    logic [COLOR_W-1:0] draw_color_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic               buffer_select_reg;

    // line state
    logic               steep_reg;
    logic               active_reg;
    logic [COORD_W-1:0] major_pos_reg;
    logic [COORD_W-1:0] major_end_reg;
    logic [MB-1:0]      minor_acc_reg;
    logic [SW-1:0]      slope_reg;

    // setup working registers
    logic [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COORD_W-1:0] maj0_reg, min0_reg, maj1_reg, min1_reg;
    logic [COORD_W-1:0] dmaj_reg, dmin_reg;
    logic               neg_reg;

    // pixel working registers
    logic               sel_reg;
    logic [PIX_W-1:0]   col_reg, row_reg;
    logic [WW-1:0]      wt_reg;
    logic               done_reg;
    logic               last_reg;
    logic [MUL_W-1:0]   bit_reg;
    logic [OFF_W-1:0]   off_acc_reg;
    logic [AW-1:0]      a_acc_reg;

    // output register
    logic               out_valid_reg;
    logic [PIX_W-1:0]   pixel_col_reg, pixel_row_reg;
    logic [COLOR_W-1:0] pixel_color_reg;
    logic [OFF_W-1:0]   byte_offset_reg;
    logic               buffer_reg, line_done_reg, last_reg_out;

    alr_state_t state_reg, state_next;
    logic       div_start;
    logic       div_done;
    logic [WW-1:0] div_q;
    logic       can_load;

    // divider for the gradient magnitude
    alr_div #(
        .GRAD_FRAC_BITS (GRAD_FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (dmin_reg),
        .den      (dmaj_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign can_load = !out_valid_reg || out_ready;

    // axis choice from endpoint deltas
    logic [COORD_W-1:0] adx, ady;
    logic               steep_n;
    assign adx     = (sx_reg > ex_reg) ? sx_reg - ex_reg : ex_reg - sx_reg;
    assign ady     = (sy_reg > ey_reg) ? sy_reg - ey_reg : ey_reg - sy_reg;
    assign steep_n = ady > adx;

    // endpoint ordering by major axis
    logic               swap;
    logic [COORD_W-1:0] maj_s, maj_e, min_s, min_e;
    assign swap  = maj1_reg < maj0_reg;
    assign maj_s = swap ? maj1_reg : maj0_reg;
    assign maj_e = swap ? maj0_reg : maj1_reg;
    assign min_s = swap ? min1_reg : min0_reg;
    assign min_e = swap ? min0_reg : min1_reg;

    // per-column quantities from the line state
    logic [WIDE_W-1:0]         m_wide, cm_wide;
    logic [GRAD_FRAC_BITS-1:0] frac;
    logic [PIX_W-1:0]          minor_px, major_px;
    logic                      col_done;
    assign m_wide   = WIDE_W'(minor_acc_reg[MB-1:GRAD_FRAC_BITS]);
    assign cm_wide  = WIDE_W'(major_pos_reg[COORD_W-1:CFB]);
    assign frac     = minor_acc_reg[GRAD_FRAC_BITS-1:0];
    assign minor_px = m_wide[PIX_W-1:0] + PIX_W'(sel_reg);
    assign major_px = cm_wide[PIX_W-1:0];
    assign col_done = ({1'b0, major_pos_reg} + COORD_ONE) > {1'b0, major_end_reg};

    // serial multiply bits, msb first
    logic [PIX_W-1:0] alpha_wide, bpp_wide;
    logic             row_bit, bpp_bit, alpha_bit;
    assign alpha_wide = PIX_W'(draw_color_reg[COLOR_W-1:ALPHA_LO]);
    assign bpp_wide   = PIX_W'(bpp_reg);
    assign row_bit    = row_reg[bit_reg];
    assign bpp_bit    = bpp_wide[bit_reg];
    assign alpha_bit  = alpha_wide[bit_reg];

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_SETUP)
                        state_next = ST_SET_AXES;
                    else if (active_reg)
                        state_next = ST_PIX_SETUP;
                end
            end
            ST_SET_AXES:  state_next = ST_SET_ORDER;
            ST_SET_ORDER: state_next = ST_DIV_GO;
            ST_DIV_GO:
            begin
                if (dmaj_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            ST_PIX_SETUP: state_next = ST_PIX_MUL;
            ST_PIX_MUL:
            begin
                if (bit_reg == '0)
                    state_next = ST_PIX_EMIT;
            end
            ST_PIX_EMIT:
            begin
                if (can_load)
                    state_next = last_reg ? ST_IDLE : ST_PIX_SETUP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg    <= DRAW_COLOR_RST;
            row_pitch_reg     <= ROW_PITCH_RST;
            bpp_reg           <= BPP_RST;
            buffer_select_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRAW_COLOR:    draw_color_reg    <= cfg_data;
                CFG_ROW_PITCH:     row_pitch_reg     <= cfg_data[PITCH_W-1:0];
                CFG_BYTES_PER_PIX: bpp_reg           <= cfg_data[BPP_W-1:0];
                CFG_BUFFER_SELECT: buffer_select_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // line state: setup loads it, the last pixel of a column advances it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steep_reg     <= 1'b0;
            active_reg    <= 1'b0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            minor_acc_reg <= '0;
            slope_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_SET_AXES:
                    steep_reg <= steep_n;
                ST_SET_ORDER:
                begin
                    major_pos_reg <= maj_s;
                    major_end_reg <= maj_e;
                    minor_acc_reg <= MB'(min_s) << MINOR_SH;
                end
                ST_DIV_GO:
                begin
                    if (dmaj_reg == '0)
                    begin
                        slope_reg  <= SW'(WEIGHT_ONE);
                        active_reg <= 1'b1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        slope_reg  <= neg_reg ? SW'(0) - SW'(div_q) : SW'(div_q);
                        active_reg <= 1'b1;
                    end
                end
                ST_PIX_EMIT:
                begin
                    if (can_load && last_reg)
                    begin
                        if (done_reg)
                            active_reg <= 1'b0;
                        else
                        begin
                            major_pos_reg <= major_pos_reg + COORD_ONE[COORD_W-1:0];
                            minor_acc_reg <= minor_acc_reg
                                           + {{(MB-SW){slope_reg[SW-1]}}, slope_reg};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // setup and pixel datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sx_reg  <= start_x;
                sy_reg  <= start_y;
                ex_reg  <= end_x;
                ey_reg  <= end_y;
                sel_reg <= 1'b0;
            end
            ST_SET_AXES:
            begin
                maj0_reg <= steep_n ? sy_reg : sx_reg;
                min0_reg <= steep_n ? sx_reg : sy_reg;
                maj1_reg <= steep_n ? ey_reg : ex_reg;
                min1_reg <= steep_n ? ex_reg : ey_reg;
            end
            ST_SET_ORDER:
            begin
                dmaj_reg <= maj_e - maj_s;
                neg_reg  <= min_e < min_s;
                dmin_reg <= (min_e < min_s) ? min_s - min_e : min_e - min_s;
            end
            ST_PIX_SETUP:
            begin
                col_reg     <= steep_reg ? minor_px : major_px;
                row_reg     <= steep_reg ? major_px : minor_px;
                wt_reg      <= sel_reg ? WW'(frac) : WEIGHT_ONE - WW'(frac);
                done_reg    <= col_done;
                last_reg    <= sel_reg || (frac == '0);
                bit_reg     <= MUL_W'(PIX_W - 1);
                off_acc_reg <= '0;
                a_acc_reg   <= '0;
            end
            ST_PIX_MUL:
            begin
                off_acc_reg <= {off_acc_reg[OFF_W-2:0], 1'b0}
                             + (row_bit ? OFF_W'(row_pitch_reg) : OFF_W'(0))
                             + (bpp_bit ? OFF_W'(col_reg) : OFF_W'(0));
                a_acc_reg   <= {a_acc_reg[AW-2:0], 1'b0}
                             + (alpha_bit ? AW'(wt_reg) : AW'(0));
                if (bit_reg != '0)
                    bit_reg <= bit_reg - 1'b1;
            end
            ST_PIX_EMIT:
            begin
                if (can_load)
                    sel_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_PIX_EMIT && can_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PIX_EMIT && can_load)
        begin
            pixel_col_reg   <= col_reg;
            pixel_row_reg   <= row_reg;
            pixel_color_reg <= {a_acc_reg[AW-1:GRAD_FRAC_BITS],
                                draw_color_reg[ALPHA_LO-1:0]};
            byte_offset_reg <= off_acc_reg;
            buffer_reg      <= buffer_select_reg;
            line_done_reg   <= done_reg;
            last_reg_out    <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_col   = pixel_col_reg;
    assign pixel_row   = pixel_row_reg;
    assign pixel_color = pixel_color_reg;
    assign byte_offset = byte_offset_reg;
    assign buffer      = buffer_reg;
    assign line_done   = line_done_reg;
    assign last        = last_reg_out;

endmodule

`default_nettype wire

>>> sv/alr_div.sv
// bit-serial restoring divider for the line gradient, one quotient bit per cycle
`default_nettype none

module alr_div
    import alr_pkg::*;
#(
    parameter int GRAD_FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [COORD_W-1:0]        num,
    input  wire logic [COORD_W-1:0]        den,
    output logic                           done,
    output logic [GRAD_FRAC_BITS:0]        quotient
);

    localparam int CW = $clog2(GRAD_FRAC_BITS + 1);

    logic                     running_reg;
    logic [CW-1:0]            cnt_reg;
    logic [COORD_W-1:0]       rem_reg;
    logic [COORD_W-1:0]       den_reg;
    logic [GRAD_FRAC_BITS:0]  quo_reg;
    logic [COORD_W:0]         rem_sh;
    logic                     fits;
    logic [COORD_W:0]         rem_sub;

    // one trial subtract per cycle on the shifted remainder
    assign rem_sh  = {rem_reg, 1'b0};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign done     = running_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    // control: run for one step per fraction bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (start)
        begin
            running_reg <= 1'b1;
            cnt_reg     <= CW'(GRAD_FRAC_BITS);
        end
        else if (running_reg)
        begin
            if (cnt_reg == '0)
                running_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath: integer part settled at start (numerator never exceeds divisor)
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (num >= den)
            begin
                rem_reg <= num - den;
                quo_reg <= (GRAD_FRAC_BITS+1)'(1);
            end
            else
            begin
                rem_reg <= num;
                quo_reg <= '0;
            end
        end
        else if (running_reg && (cnt_reg != '0))
        begin
            rem_reg <= fits ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
            quo_reg <= {quo_reg[GRAD_FRAC_BITS-1:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_antialiased_line_rasterizer.sv
// testbench for the antialiased line rasterizer: line items checked against a wu-style predictor
`timescale 1ns / 1ps

module tb_antialiased_line_rasterizer
    import alr_pkg::*;
();

    localparam int COORD_FRAC  = 4;
    localparam int GRAD_FRAC   = 16;
    localparam int COORD_ONE   = 1 << COORD_FRAC;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int MINOR_W     = 28;
    localparam int SLOPE_W     = 18;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_SPAN   = 1008;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 300;
    localparam logic [GRAD_FRAC:0] FULL_WEIGHT = (GRAD_FRAC+1)'(1) << GRAD_FRAC;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        int                 gap;
        bit                 drain;
    } line_item_t;

    typedef struct {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [OFF_W-1:0]   offset;
        logic               fb_sel;
        logic               done;
        logic               last_pix;
    } pixel_t;

    // dut ports
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     pixel_col;
    logic [PIX_W-1:0]     pixel_row;
    logic [COLOR_W-1:0]   pixel_color;
    logic [OFF_W-1:0]     byte_offset;
    logic                 buffer;
    logic                 line_done;
    logic                 last;

    // predicted line state and register copies
    logic                      ln_steep;
    logic                      ln_active;
    logic [COORD_W-1:0]        ln_major;
    logic [COORD_W-1:0]        ln_major_end;
    logic [MINOR_W-1:0]        ln_minor;
    logic signed [SLOPE_W-1:0] ln_slope;
    logic [COLOR_W-1:0]        pc_color;
    logic [PITCH_W-1:0]        pc_pitch;
    logic [BPP_W-1:0]          pc_bpp;
    logic                      pc_fb;

    // item traffic bookkeeping
    line_item_t pending_items[$];
    pixel_t     expected_pixels[$];
    line_item_t held_item;
    bit         item_held = 1'b0;
    int         gap_left = 0;
    int         in_sent = 0;
    int         in_taken = 0;
    int         out_taken = 0;
    int         out_seen = 0;
    int         stall_left = 0;
    int         hold_token = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         mismatches = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    bit         drain_next = 1'b0;

    antialiased_line_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .pixel_color (pixel_color),
        .byte_offset (byte_offset),
        .buffer      (buffer),
        .line_done   (line_done),
        .last        (last)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one pixel with its weighted alpha and framebuffer offset
    function automatic pixel_t plot_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                          logic [GRAD_FRAC:0] weight, logic done);
        pixel_t      p;
        logic [31:0] alpha;
        logic [63:0] off;
        alpha = (32'(pc_color[ALPHA_LO +: ALPHA_W]) * 32'(weight)) >> GRAD_FRAC;
        off = 64'(row) * 64'(pc_pitch) + 64'(col) * 64'(pc_bpp);
        p.col = col;
        p.row = row;
        p.color = {alpha[ALPHA_W-1:0], pc_color[ALPHA_LO-1:0]};
        p.offset = off[OFF_W-1:0];
        p.fb_sel = pc_fb;
        p.done = done;
        p.last_pix = 1'b0;
        return p;
    endfunction

    // line setup or one column step, pushing the pixels it should produce
    task automatic rasterize(input logic k, input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        logic [COORD_W-1:0]           adx, ady, maj0, maj1, min0, min1, dmaj, dmin, t;
        logic [COORD_W+GRAD_FRAC-1:0] quo;
        logic                         neg, done;
        logic [PIX_W-1:0]             col_major, m;
        logic [GRAD_FRAC-1:0]         frac;
        logic [GRAD_FRAC:0]           w0;
        pixel_t                       p0, p1;
        if (k == KIND_SETUP)
        begin
            adx = (sx > ex) ? sx - ex : ex - sx;
            ady = (sy > ey) ? sy - ey : ey - sy;
            ln_steep = ady > adx;
            if (ln_steep)
            begin
                maj0 = sy; min0 = sx; maj1 = ey; min1 = ex;
            end
            else
            begin
                maj0 = sx; min0 = sy; maj1 = ex; min1 = ey;
            end
            // order endpoints along the major axis
            if (maj1 < maj0)
            begin
                t = maj0; maj0 = maj1; maj1 = t;
                t = min0; min0 = min1; min1 = t;
            end
            dmaj = maj1 - maj0;
            neg = min1 < min0;
            dmin = neg ? min0 - min1 : min1 - min0;
            // truncated magnitude, sign applied after
            if (dmaj == 0)
                ln_slope = SLOPE_W'(FULL_WEIGHT);
            else
            begin
                quo = {dmin, {GRAD_FRAC{1'b0}}} / dmaj;
                ln_slope = neg ? -SLOPE_W'(quo) : SLOPE_W'(quo);
            end
            ln_major = maj0;
            ln_major_end = maj1;
            ln_minor = MINOR_W'(min0) << (GRAD_FRAC - COORD_FRAC);
            ln_active = 1'b1;
        end
        else if (ln_active)
        begin
            col_major = PIX_W'(ln_major >> COORD_FRAC);
            m = ln_minor[GRAD_FRAC +: PIX_W];
            frac = ln_minor[GRAD_FRAC-1:0];
            w0 = FULL_WEIGHT - {1'b0, frac};
            done = (ln_major_end < ln_major) || (ln_major_end - ln_major < COORD_ONE);
            if (ln_steep)
                p0 = plot_pixel(m, col_major, w0, done);
            else
                p0 = plot_pixel(col_major, m, w0, done);
            // neighbor on the minor axis only when it has coverage
            if (frac != 0)
            begin
                if (ln_steep)
                    p1 = plot_pixel(m + 1'b1, col_major, {1'b0, frac}, done);
                else
                    p1 = plot_pixel(col_major, m + 1'b1, {1'b0, frac}, done);
                p1.last_pix = 1'b1;
                expected_pixels.push_back(p0);
                expected_pixels.push_back(p1);
            end
            else
            begin
                p0.last_pix = 1'b1;
                expected_pixels.push_back(p0);
            end
            if (done)
                ln_active = 1'b0;
            else
            begin
                ln_major = ln_major + COORD_W'(COORD_ONE);
                ln_minor = ln_minor + MINOR_W'(ln_slope);
            end
        end
    endtask

    // field by field comparison of one accepted pixel
    task automatic compare_pixel(input pixel_t want);
        if (pixel_col !== want.col)
        begin
            $error("pixel_col: expected %0d, got %0d", want.col, pixel_col);
            mismatches++;
        end
        if (pixel_row !== want.row)
        begin
            $error("pixel_row: expected %0d, got %0d", want.row, pixel_row);
            mismatches++;
        end
        if (pixel_color !== want.color)
        begin
            $error("pixel_color: expected %h, got %h", want.color, pixel_color);
            mismatches++;
        end
        if (byte_offset !== want.offset)
        begin
            $error("byte_offset: expected %0d, got %0d", want.offset, byte_offset);
            mismatches++;
        end
        if (buffer !== want.fb_sel)
        begin
            $error("buffer: expected %0d, got %0d", want.fb_sel, buffer);
            mismatches++;
        end
        if (line_done !== want.done)
        begin
            $error("line_done: expected %0d, got %0d", want.done, line_done);
            mismatches++;
        end
        if (last !== want.last_pix)
        begin
            $error("last: expected %0d, got %0d", want.last_pix, last);
            mismatches++;
        end
    endtask

    // monitor: predict on accepted items, check accepted pixels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel: col %0d row %0d", pixel_col, pixel_row);
                    mismatches++;
                end
                else
                    compare_pixel(expected_pixels.pop_front());
                out_taken <= out_taken + 1;
            end
            if (in_valid && in_ready)
            begin
                rasterize(kind, start_x, start_y, end_x, end_y);
                in_taken <= in_taken + 1;
            end
            if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // driver: offers queued items after each one's gap
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_taken != in_sent))
        begin
            if (!item_held && pending_items.size() != 0)
            begin
                held_item = pending_items.pop_front();
                item_held = 1'b1;
                gap_left = held_item.gap;
            end
            if (item_held && gap_left == 0 && (!held_item.drain || expected_pixels.size() == 0))
            begin
                in_valid <= 1'b1;
                kind <= held_item.kind;
                start_x <= held_item.sx;
                start_y <= held_item.sy;
                end_x <= held_item.ex;
                end_y <= held_item.ey;
                in_sent++;
                item_held = 1'b0;
            end
            else
            begin
                in_valid <= 1'b0;
                if (item_held && gap_left != 0)
                    gap_left--;
            end
        end
    end

    // receiver: random stall after each pixel, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (out_seen != out_taken)
        begin
            out_seen = out_taken;
            stall_left = rx_calm ? 0 : $urandom_range(0, 15);
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles with no accepted traffic
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    task automatic queue_item(input logic k, input logic [COORD_W-1:0] sx,
                              input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] ex,
                              input logic [COORD_W-1:0] ey);
        line_item_t it;
        it.kind = k;
        it.sx = sx;
        it.sy = sy;
        it.ex = ex;
        it.ey = ey;
        it.gap = tx_calm ? 0 : $urandom_range(0, 15);
        it.drain = drain_next;
        drain_next = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic queue_step();
        queue_item(KIND_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
    endtask

    // random line followed by its column steps, sometimes cut short or overrun
    task automatic queue_line(input int max_span, inout int count);
        int sx, sy, ex, ey, dx, dy, cols, steps;
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        dx = $urandom_range(0, max_span);
        dy = $urandom_range(0, max_span);
        case ($urandom_range(0, 7))
            0: dx = 0;
            1: dy = 0;
            2: dy = dx;
            default: ;
        endcase
        ex = sx + ($urandom_range(0, 1) ? dx : -dx);
        ey = sy + ($urandom_range(0, 1) ? dy : -dy);
        if (ex < 0) ex = 0;
        if (ex > COORD_MAX) ex = COORD_MAX;
        if (ey < 0) ey = 0;
        if (ey > COORD_MAX) ey = COORD_MAX;
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        cols = ((dx > dy) ? dx : dy) / COORD_ONE + 1;
        steps = cols;
        case ($urandom_range(0, 9))
            0: steps = $urandom_range(0, cols);
            1: steps = cols + $urandom_range(1, 3);
            default: ;
        endcase
        queue_item(KIND_SETUP, COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey));
        repeat (steps)
            queue_step();
        count += 1 + ((steps < cols) ? steps : cols);
    endtask

    // waits until every queued item is taken and every pixel has arrived
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_items.size() != 0 || item_held || (in_valid && in_taken != in_sent)
               || expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // register writes once the block has settled
    task automatic load_config(input logic [COLOR_W-1:0] color, input logic [PITCH_W-1:0] pitch,
                               input logic [BPP_W-1:0] bpp, input logic fb);
        repeat (SETTLE) @(negedge clk);
        write_reg(CFG_DRAW_COLOR, color);
        write_reg(CFG_ROW_PITCH, COLOR_W'(pitch));
        write_reg(CFG_BYTES_PER_PIX, COLOR_W'(bpp));
        write_reg(CFG_BUFFER_SELECT, COLOR_W'(fb));
        pc_color = color;
        pc_pitch = pitch;
        pc_bpp = bpp;
        pc_fb = fb;
    endtask

    // one configuration phase of random lines
    task automatic run_phase(input bit calm_rx, input bit with_hold);
        int count;
        int lines;
        int hy;
        count = 0;
        lines = 0;
        rx_calm = calm_rx;
        // one shallow line sent back to back in the hold-off phase
        if (with_hold)
        begin
            tx_calm = 1'b1;
            hy = $urandom_range(0, COORD_MAX - HOLD_SPAN);
            queue_item(KIND_SETUP, '0, COORD_W'(hy), COORD_W'(HOLD_SPAN),
                       COORD_W'(hy + $urandom_range(0, HOLD_SPAN)));
            repeat (HOLD_SPAN / COORD_ONE + 1)
                queue_step();
            count += HOLD_SPAN / COORD_ONE + 2;
        end
        while (count < PHASE_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if (lines == 10 || $urandom_range(0, 24) == 0)
                drain_next = 1'b1;
            queue_line(($urandom_range(0, 15) == 0) ? 640 : 160, count);
            if ($urandom_range(0, 11) == 0)
                queue_step();
            lines++;
        end
        if (with_hold)
            hold_token++;
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_SETUP;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        out_ready = 1'b0;
        ln_steep = 1'b0;
        ln_active = 1'b0;
        ln_major = '0;
        ln_major_end = '0;
        ln_minor = '0;
        ln_slope = '0;
        pc_color = DRAW_COLOR_RST;
        pc_pitch = ROW_PITCH_RST;
        pc_bpp = BPP_RST;
        pc_fb = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: step with no line, then a shallow line and an overrun step
        tx_calm = $urandom_range(0, 1);
        queue_item(KIND_STEP, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        queue_item(KIND_SETUP, 15'h0000, 15'h0000, 15'h0030, 15'h0008);
        repeat (5) queue_step();
        // zero-length line has one column
        queue_item(KIND_SETUP, 15'h1235, 15'h0444, 15'h1235, 15'h0444);
        queue_step();
        // steep, negative gradient, fractional start
        queue_item(KIND_SETUP, 15'h0109, 15'h0213, 15'h00F2, 15'h0257);
        repeat (5) queue_step();
        // far corner of the coordinate range
        queue_item(KIND_SETUP, 15'h7FFF, 15'h7FFF, 15'h7FCF, 15'h7FEF);
        repeat (4) queue_step();
        // long line replaced mid-way by a vertical one
        queue_item(KIND_SETUP, 15'h0000, 15'h7FFF, 15'h7FFF, 15'h0000);
        queue_step();
        queue_item(KIND_SETUP, 15'h0050, 15'h0000, 15'h0050, 15'h0020);
        repeat (3) queue_step();
        wait_idle();

        // low extremes
        load_config(32'h00A5_5A3C, 15'd1, 3'd1, 1'b1);
        run_phase(1'b0, 1'b0);
        // high extremes, no receiver idling, long hold-off
        load_config(32'hFFFF_FFFF, 15'd16384, 3'd4, 1'b0);
        run_phase(1'b1, 1'b1);
        // values past the stated ranges
        load_config($urandom, 15'h7FFF, 3'd7, 1'b1);
        run_phase(1'b0, 1'b0);
        load_config($urandom, 15'd0, 3'd0, 1'b0);
        run_phase(1'b0, 1'b0);
        // random legal setting
        load_config($urandom, PITCH_W'($urandom_range(1, 16384)), BPP_W'($urandom_range(1, 4)),
                    1'($urandom));
        run_phase(1'b0, 1'b0);

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
